// ===== hdl/indexed_list_insert_erase_defines.svh =====
// Assertion helpers shared by the list block.
`ifndef INDEXED_LIST_INSERT_ERASE_DEFINES_SVH
`define INDEXED_LIST_INSERT_ERASE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ILIE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ILIE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ilie_pkg.sv =====
package ilie_pkg;

	// Field widths of the request and result items.
	localparam int unsigned REQ_W   = 3;
	localparam int unsigned IDX_W   = 7;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned LEN_W   = 7;
	localparam int unsigned ST_W    = 2;
	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 40;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ERASE  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RESIZE = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CREATE = 3'd5;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// Operations broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_ERA  = 2'd2,
		CELL_CLR  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [VAL_W-1:0]   value;
	} cell_cmd_t;

endpackage

// ===== hdl/ilie_cell.sv =====
module ilie_cell import ilie_pkg::*; #(
	parameter int unsigned IDX = 0,
	parameter int unsigned LW  = 7,
	parameter int unsigned CW  = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_cmd_t               cmd,
	input  logic [LW-1:0]           pos,
	input  logic [CW-1:0]           rd_idx,
	input  logic signed [VAL_W-1:0] left,
	input  logic signed [VAL_W-1:0] right,
	output logic signed [VAL_W-1:0] entry,
	output logic signed [VAL_W-1:0] sel
);

	localparam logic [LW-1:0] MY_POS = LW'(IDX);
	localparam logic [CW-1:0] MY_RD  = CW'(IDX);

	logic signed [VAL_W-1:0] entry_q;
	logic signed [VAL_W-1:0] entry_d;

	// Next entry: load, take from a neighbor, clear, or keep.
	always_comb begin
		entry_d = entry_q;
		case (cmd.op)
			CELL_INS: begin
				if (MY_POS == pos) begin
					entry_d = cmd.value;
				end else if (MY_POS > pos) begin
					entry_d = left;
				end
			end
			CELL_ERA: begin
				if (MY_POS >= pos) begin
					entry_d = right;
				end
			end
			CELL_CLR: begin
				if (MY_POS >= pos) begin
					entry_d = '0;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	// The entry register; reset leaves the list empty and zeroed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_d;
		end
	end

	// Only the addressed cell contributes to the read bus.
	assign sel   = (rd_idx == MY_RD) ? entry_q : '0;
	assign entry = entry_q;

endmodule

// ===== hdl/indexed_list_insert_erase.sv =====
// A result appears in the output register in the cycle after its request transfer.
// Throughput: one request per cycle; a new request is taken while a result waits if the
// output register empties in the same cycle. Insert and erase move all cells from the position on at once.
// Reset: asynchronous, active low; clears all entries to zero and the length to zero,
// with no clearing pass afterwards.
`include "indexed_list_insert_erase_defines.svh"

module indexed_list_insert_erase import ilie_pkg::*; #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// index [6:0], value [38:7], new_length [45:39], zero [47:46]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// req_type [2:0]
	input  logic [REQ_W-1:0]       s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// read_value [31:0], length [38:32], zero [39]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// status [1:0]
	output logic [ST_W-1:0]        m_tuser
);

	localparam int unsigned LW = $clog2(CAPACITY + 1);
	localparam int unsigned CW = (LW > IDX_W) ? LW : IDX_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// Request fields.
	logic [REQ_W-1:0]        req;
	logic [IDX_W-1:0]        idx;
	logic signed [VAL_W-1:0] val;
	logic [LEN_W-1:0]        nlen;

	assign req  = s_tuser;
	assign idx  = s_tdata[IDX_W-1:0];
	assign val  = s_tdata[IDX_W+VAL_W-1:IDX_W];
	assign nlen = s_tdata[IDX_W+VAL_W+LEN_W-1:IDX_W+VAL_W];

	logic          accept;
	logic [LW-1:0] len_q;
	logic [LW-1:0] len_d;
	logic [CW-1:0] len_ext;
	logic [CW-1:0] idx_ext;
	logic [CW-1:0] nlen_ext;
	cell_op_t      op_d;
	logic [LW-1:0] pos_d;
	logic [ST_W-1:0] st_d;
	logic          rd_ok;
	cell_cmd_t     cmd;

	logic                   out_valid_q;
	logic signed [VAL_W-1:0] out_rd_q;
	logic [LEN_W-1:0]       out_len_q;
	logic [ST_W-1:0]        out_st_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign len_ext  = CW'(len_q);
	assign idx_ext  = CW'(idx);
	assign nlen_ext = CW'(nlen);

	// Request decode: range and capacity checks, cell command and next length.
	always_comb begin
		op_d  = CELL_HOLD;
		pos_d = '0;
		st_d  = ST_DONE;
		rd_ok = 1'b0;
		len_d = len_q;
		case (req)
			REQ_READ: begin
				if (idx_ext >= len_ext) begin
					st_d = ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			REQ_INSERT: begin
				if (idx_ext > len_ext) begin
					st_d = ST_RANGE;
				end else if (len_ext >= CAP_C) begin
					st_d = ST_FULL;
				end else begin
					op_d  = CELL_INS;
					pos_d = LW'(idx_ext);
					len_d = len_q + LW'(1);
				end
			end
			REQ_PUSH: begin
				if (len_ext >= CAP_C) begin
					st_d = ST_FULL;
				end else begin
					op_d  = CELL_INS;
					pos_d = len_q;
					len_d = len_q + LW'(1);
				end
			end
			REQ_ERASE: begin
				if (idx_ext >= len_ext) begin
					st_d = ST_RANGE;
				end else begin
					op_d  = CELL_ERA;
					pos_d = LW'(idx_ext);
					len_d = len_q - LW'(1);
				end
			end
			REQ_RESIZE: begin
				if (nlen_ext > CAP_C) begin
					st_d = ST_FULL;
				end else begin
					op_d  = CELL_CLR;
					pos_d = LW'(nlen_ext);
					len_d = LW'(nlen_ext);
				end
			end
			REQ_CREATE: begin
				if (nlen_ext > CAP_C) begin
					st_d = ST_FULL;
				end else begin
					op_d  = CELL_CLR;
					pos_d = '0;
					len_d = LW'(nlen_ext);
				end
			end
			default: begin
				op_d = CELL_HOLD;
			end
		endcase
	end

	// The command only reaches the cells on a request transfer.
	assign cmd.op    = accept ? op_d : CELL_HOLD;
	assign cmd.value = val;

	// Chain of cells, one entry each, wired to both neighbors.
	logic signed [VAL_W-1:0] cell_q   [CAPACITY];
	logic signed [VAL_W-1:0] cell_sel [CAPACITY];

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [VAL_W-1:0] left_w;
		logic signed [VAL_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_q[g+1];
		end

		ilie_cell #(
			.IDX (g),
			.LW  (LW),
			.CW  (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.pos    (pos_d),
			.rd_idx (idx_ext),
			.left   (left_w),
			.right  (right_w),
			.entry  (cell_q[g]),
			.sel    (cell_sel[g])
		);
	end

	// Read bus: at most one cell drives a nonzero value.
	logic signed [VAL_W-1:0] rd_bus;
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_bus = rd_bus | cell_sel[i];
		end
	end

	// Length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (accept) begin
			len_q <= len_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	logic [CW-1:0] len_d_ext;
	assign len_d_ext = CW'(len_d);

	always_ff @(posedge clk) begin
		if (accept) begin
			out_rd_q  <= rd_ok ? rd_bus : '0;
			out_len_q <= len_d_ext[LEN_W-1:0];
			out_st_q  <= st_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_len_q, out_rd_q};
	assign m_tuser  = out_st_q;

	// Checks on the length bookkeeping and the result register.
	`ILIE_ASSERT_IMP(a_len_cap, 1'b1, len_q <= LW'(CAPACITY), "length above capacity")
	`ILIE_ASSERT_NXT(a_result_follows, accept, m_tvalid, "request transfer gave no result")
	`ILIE_ASSERT_NXT(a_refused_len, accept && (st_d != ST_DONE), $stable(len_q), "refused request changed length")
	`ILIE_ASSERT_IMP(a_rd_status, m_tvalid && (out_rd_q != '0), out_st_q == ST_DONE, "read data with error status")

endmodule

// ===== tb/sv/indexed_list_insert_erase_tb.sv =====
`default_nettype none

module indexed_list_insert_erase_tb;
	import ilie_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIST_CAPACITY = 64;
	localparam int unsigned LIST_IW       = $clog2(LIST_CAPACITY);
	localparam int unsigned LIMIT_CYCLES  = 400000;

	// Request codes 6 and 7 are unused and behave as a size query.
	localparam logic [REQ_W-1:0] REQ_SIZE_QUERY_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SIZE_QUERY_B = 3'd7;

	typedef struct {
		logic [VAL_W-1:0] read_value;
		logic [LEN_W-1:0] length;
		logic [ST_W-1:0]  status;
	} list_result_t;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_PATTERN
	} stall_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// index [6:0], value [38:7], new_length [45:39], zero [47:46]
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	// req_type [2:0]
	logic [REQ_W-1:0]       s_tuser = REQ_READ;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// read_value [31:0], length [38:32], zero [39]
	logic [OUT_TDATA_W-1:0] m_tdata;
	// status [1:0]
	logic [ST_W-1:0]        m_tuser;

	// Shadow copy of the list, advanced at each accepted request.
	logic [VAL_W-1:0] list_entries [LIST_CAPACITY];
	int unsigned      list_len;

	list_result_t     expected_results [$];
	int unsigned      error_count = 0;
	int unsigned      cycle_count = 0;
	int unsigned      burst_left = 0;
	stall_mode_t      ready_mode = READY_ALWAYS;
	int unsigned      ready_phase_left = 0;

	indexed_list_insert_erase #(
		.CAPACITY(LIST_CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the shadow list and return the result it must produce.
	function automatic list_result_t apply_list_request(input logic [REQ_W-1:0] op,
		input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val,
		input logic [LEN_W-1:0] nlen);
		list_result_t res;
		res.read_value = '0;
		res.status     = ST_DONE;
		case (op)
			REQ_READ: begin
				if (idx >= list_len)
					res.status = ST_RANGE;
				else
					res.read_value = list_entries[idx[LIST_IW-1:0]];
			end
			REQ_INSERT, REQ_PUSH: begin
				if (op == REQ_PUSH)
					idx = IDX_W'(list_len);
				if (idx > list_len) begin
					res.status = ST_RANGE;
				end else if (list_len >= LIST_CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (int i = list_len; i > idx; i--)
						list_entries[i] = list_entries[i - 1];
					list_entries[idx[LIST_IW-1:0]] = val;
					list_len++;
				end
			end
			REQ_ERASE: begin
				if (idx >= list_len) begin
					res.status = ST_RANGE;
				end else begin
					for (int i = int'(idx); i + 1 < list_len; i++)
						list_entries[i] = list_entries[i + 1];
					list_entries[list_len - 1] = '0;
					list_len--;
				end
			end
			REQ_RESIZE, REQ_CREATE: begin
				if (nlen > LIST_CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					// Create wipes everything; resize only clears from the new end on.
					for (int i = 0; i < LIST_CAPACITY; i++)
						if (op == REQ_CREATE || i >= nlen)
							list_entries[i] = '0;
					list_len = 32'(nlen);
				end
			end
			default: begin
			end
		endcase
		res.length = list_len[LEN_W-1:0];
		return res;
	endfunction

	// Present one request, wait for its transfer, record the expected result,
	// then possibly drop valid for a random gap before the next burst.
	task automatic send_request(input logic [REQ_W-1:0] op, input logic [IDX_W-1:0] idx,
		input logic [VAL_W-1:0] val, input logic [LEN_W-1:0] nlen);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, nlen, val, idx};
		do
			@(posedge clk);
		while (!s_tready);
		expected_results.push_back(apply_list_request(op, idx, val, nlen));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 20);
		end
	endtask

	// Reads, erases and size queries on an empty list.
	task automatic test_empty_list();
		send_request(REQ_READ, 7'd64, 32'h0, 7'd0);
		send_request(REQ_ERASE, 7'd0, 32'h0, 7'd0);
		send_request(REQ_SIZE_QUERY_A, 7'd0, 32'hFFFF_FFFF, 7'd3);
		send_request(REQ_SIZE_QUERY_B, 7'd1, 32'h0, 7'd0);
	endtask

	// Insert at the front, middle and end, then erase at the front, middle and end.
	task automatic test_shift_ops();
		send_request(REQ_PUSH, 7'd0, 32'h7FFF_FFFF, 7'd0);
		send_request(REQ_PUSH, 7'd0, 32'h8000_0000, 7'd0);
		send_request(REQ_INSERT, 7'd0, 32'hFFFF_FFFF, 7'd0);
		send_request(REQ_INSERT, 7'd1, 32'h5555_5555, 7'd0);
		send_request(REQ_INSERT, 7'd4, 32'hAAAA_AAAA, 7'd0);
		send_request(REQ_INSERT, 7'd6, 32'h1234_5678, 7'd0);
		send_request(REQ_READ, 7'd0, 32'h0, 7'd0);
		send_request(REQ_READ, 7'd5, 32'h0, 7'd0);
		send_request(REQ_ERASE, 7'd0, 32'h0, 7'd0);
		send_request(REQ_ERASE, 7'd1, 32'h0, 7'd0);
		send_request(REQ_ERASE, 7'd2, 32'h0, 7'd0);
	endtask

	// Full list, oversize lengths, shrinking and growing resize.
	task automatic test_length_ops();
		send_request(REQ_CREATE, 7'd0, 32'h0, 7'd64);
		send_request(REQ_PUSH, 7'd0, 32'h0000_0001, 7'd0);
		send_request(REQ_INSERT, 7'd10, 32'h0000_0002, 7'd0);
		// An index past the length wins over the full check.
		send_request(REQ_INSERT, 7'd65, 32'h0000_0003, 7'd0);
		send_request(REQ_READ, 7'd63, 32'h0, 7'd0);
		send_request(REQ_RESIZE, 7'd0, 32'h0, 7'd65);
		send_request(REQ_RESIZE, 7'd0, 32'h0, 7'd2);
		send_request(REQ_RESIZE, 7'd0, 32'h0, 7'd5);
		send_request(REQ_READ, 7'd4, 32'h0, 7'd0);
		send_request(REQ_CREATE, 7'd0, 32'h0, 7'd127);
	endtask

	// Random requests whose mix drifts between growing, shrinking and balanced,
	// so the length sweeps from empty to full.
	task automatic test_random_traffic(input int unsigned count);
		// Cumulative weights for read, insert, push, erase, resize, create, query.
		int unsigned      cut [3][7] = '{
			'{15, 50, 85, 93, 96, 98, 100},
			'{20, 30, 40, 80, 92, 97, 100},
			'{20, 42, 60, 85, 92, 97, 100}
		};
		logic [REQ_W-1:0] op_order [6] = '{REQ_READ, REQ_INSERT, REQ_PUSH, REQ_ERASE,
			REQ_RESIZE, REQ_CREATE};
		int unsigned      bias;
		int unsigned      pick;
		int unsigned      k;
		logic [REQ_W-1:0] op;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		logic [LEN_W-1:0] nlen;
		bias = 0;
		for (int unsigned n = 0; n < count; n++) begin
			if (n % 100 == 0)
				bias = $urandom_range(0, 2);
			pick = $urandom_range(0, 99);
			k = 0;
			while (pick >= cut[bias][k])
				k++;
			if (k < 6)
				op = op_order[k];
			else
				op = $urandom_range(0, 1) ? REQ_SIZE_QUERY_A : REQ_SIZE_QUERY_B;
			case ($urandom_range(0, 9))
				0: idx = IDX_W'($urandom_range(0, 64));
				1: idx = IDX_W'(list_len);
				default: idx = IDX_W'($urandom_range(0, list_len));
			endcase
			case ($urandom_range(0, 19))
				0: nlen = LEN_W'($urandom_range(65, 127));
				1: nlen = 7'd64;
				2: nlen = 7'd0;
				default: nlen = LEN_W'($urandom_range(0, 64));
			endcase
			case ($urandom_range(0, 15))
				0: val = 32'h8000_0000;
				1: val = 32'h7FFF_FFFF;
				2: val = 32'hFFFF_FFFF;
				3: val = 32'h0;
				default: val = $urandom;
			endcase
			send_request(op, idx, val, nlen);
		end
	endtask

	// Receiver: ready follows a stall mode that is picked anew at random when its phase runs out.
	always @(posedge clk) begin
		if (ready_phase_left == 0) begin
			ready_mode       <= stall_mode_t'($urandom_range(0, 3));
			ready_phase_left <= $urandom_range(20, 300);
		end else begin
			ready_phase_left <= ready_phase_left - 1;
		end
		case (ready_mode)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_COIN: m_tready <= 1'($urandom_range(0, 1));
			READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (cycle_count % 5 != 4) && (cycle_count % 13 > 2);
		endcase
	end

	// Compare each result transfer with the oldest expected result.
	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result: read_value=%h length=%0d status=%0d",
						m_tdata[31:0], m_tdata[38:32], m_tuser);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[31:0] !== want.read_value || m_tdata[38:32] !== want.length
						|| m_tuser !== want.status) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: expected read_value=%h length=%0d status=%0d, %s",
							want.read_value, want.length, want.status,
							$sformatf("got read_value=%h length=%0d status=%0d",
								m_tdata[31:0], m_tdata[38:32], m_tuser));
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < LIST_CAPACITY; i++)
			list_entries[i] = '0;
		list_len = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_shift_ops();
		test_length_ops();
		test_random_traffic(1250);
		s_tvalid <= 1'b0;

		// Drain outstanding results, then give a stray result time to show up.
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
